FILE: sv/fbuf_pkg.sv
`timescale 1ns / 1ps

package fbuf_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_FLIP  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam int CAP_MAX = 2047;
    localparam logic [10:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [63:0] get_value;
        logic [1:0]  status;
        logic [10:0] position;
        logic [10:0] limit;
    } res_t;

endpackage

FILE: sv/fbuf_ram.sv
`timescale 1ns / 1ps

module fbuf_ram #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/fbuf_ctrl.sv
`timescale 1ns / 1ps

module fbuf_ctrl #(
    parameter int AW = 10,
    parameter logic [10:0] BOUND_RESET = 11'd1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     opcode,
    input  logic [1:0]     size_code,
    input  logic [63:0]    put_value,
    input  logic [10:0]    capacity,
    output logic           busy,
    output logic           done,
    output fbuf_pkg::res_t result,
    output logic           mem_we,
    output logic [AW-1:0]  mem_addr,
    output logic [7:0]     mem_wdata,
    input  logic [7:0]     mem_rdata
);

    import fbuf_pkg::*;

    localparam int SW = (AW > 12) ? AW : 12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT,
        S_GET,
        S_GET_TAIL
    } state_t;

    state_t      state_reg;
    logic [10:0] cursor_reg;
    logic [10:0] bound_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  last_reg;
    logic [63:0] shift_reg;
    logic        pend_reg;
    logic        done_reg;
    logic [63:0] get_value_reg;
    logic [1:0]  status_reg;

    logic [3:0]    nbytes;
    logic [11:0]   end_pos;
    logic          fits;
    logic [63:0]   aligned;
    logic [SW-1:0] addr_sum;
    logic [63:0]   gathered;
    logic [10:0]   advanced;

    assign nbytes   = 4'd1 << size_code;
    assign end_pos  = {1'b0, cursor_reg} + 12'(nbytes);
    assign fits     = end_pos <= {1'b0, bound_reg};
    assign addr_sum = SW'(cursor_reg) + SW'(cnt_reg);
    assign gathered = {shift_reg[55:0], mem_rdata};
    assign advanced = cursor_reg + 11'(last_reg) + 11'd1;

    always_comb
    begin
        case (size_code)
            2'd0:    aligned = {put_value[7:0], 56'd0};
            2'd1:    aligned = {put_value[15:0], 48'd0};
            2'd2:    aligned = {put_value[31:0], 32'd0};
            default: aligned = put_value;
        endcase
    end

    assign mem_we    = (state_reg == S_PUT);
    assign mem_addr  = addr_sum[AW-1:0];
    assign mem_wdata = shift_reg[63:56];

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign result.get_value = get_value_reg;
    assign result.status    = status_reg;
    assign result.position  = cursor_reg;
    assign result.limit     = bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= 11'd0;
            bound_reg     <= BOUND_RESET;
            cnt_reg       <= 3'd0;
            last_reg      <= 3'd0;
            shift_reg     <= 64'd0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            get_value_reg <= 64'd0;
            status_reg    <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg       <= 3'd0;
                        last_reg      <= 3'(nbytes - 4'd1);
                        pend_reg      <= 1'b0;
                        get_value_reg <= 64'd0;
                        status_reg    <= ST_OK;
                        case (opcode)
                            OP_PUT:
                            begin
                                shift_reg <= aligned;
                                if (fits)
                                begin
                                    state_reg <= S_PUT;
                                end
                                else
                                begin
                                    status_reg <= ST_OVERFLOW;
                                    done_reg   <= 1'b1;
                                end
                            end
                            OP_GET:
                            begin
                                shift_reg <= 64'd0;
                                if (fits)
                                begin
                                    state_reg <= S_GET;
                                end
                                else
                                begin
                                    status_reg <= ST_UNDERFLOW;
                                    done_reg   <= 1'b1;
                                end
                            end
                            OP_FLIP:
                            begin
                                bound_reg  <= cursor_reg;
                                cursor_reg <= 11'd0;
                                done_reg   <= 1'b1;
                            end
                            default:
                            begin
                                bound_reg  <= capacity;
                                cursor_reg <= 11'd0;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PUT:
                begin
                    // advance to the next byte, most significant first
                    shift_reg <= {shift_reg[55:0], 8'd0};
                    if (cnt_reg == last_reg)
                    begin
                        cursor_reg <= advanced;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_GET:
                begin
                    if (pend_reg)
                    begin
                        shift_reg <= gathered;
                    end
                    pend_reg <= 1'b1;
                    if (cnt_reg == last_reg)
                    begin
                        state_reg <= S_GET_TAIL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_GET_TAIL:
                begin
                    get_value_reg <= gathered;
                    cursor_reg    <= advanced;
                    pend_reg      <= 1'b0;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/big_endian_field_buffer.sv
`timescale 1ns / 1ps

// Byte buffer with a position and a limit for packing and parsing
// big-endian fields of 1, 2, 4 or 8 bytes.
// Command channel: drive opcode, size_code and put_value with start; the
// word is taken at a clock edge where start is high and busy is low.
// Result channel: done is high for one cycle with get_value, status,
// position_now and limit_now; the receiver has no way to stall it.
// Configuration: buffer_capacity is written at any edge where
// buffer_capacity_write is high; only the next clear picks it up.
// Flip, clear and refused accesses need no work state; a put steps
// through its bytes in S_PUT, a get in S_GET and then S_GET_TAIL, and
// no word is taken while busy. Bytes move one per cycle through the
// single port of the byte store, whose read data comes the next cycle.
// The result appears the cycle after the last work cycle.
// Reset clears position to zero and sets the limit to the smaller of
// 1024 and DEPTH; capacity returns to 1024. The byte store is not
// cleared and keeps its contents across reset.
module big_endian_field_buffer #(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [1:0]  size_code,
    input  logic [63:0] put_value,
    output logic        done,
    output logic [63:0] get_value,
    output logic [1:0]  status,
    output logic [10:0] position_now,
    output logic [10:0] limit_now,
    input  logic        buffer_capacity_write,
    input  logic [10:0] buffer_capacity
);

    import fbuf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int DCAP = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;
    localparam int BRST = (DEPTH < 1024) ? DEPTH : 1024;

    logic [10:0] capacity_reg;
    logic [10:0] eff_capacity;
    res_t        result;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (buffer_capacity_write)
        begin
            capacity_reg <= buffer_capacity;
        end
    end

    assign eff_capacity = (capacity_reg > 11'(DCAP)) ? 11'(DCAP) : capacity_reg;

    fbuf_ctrl #(
        .AW          (AW),
        .BOUND_RESET (11'(BRST))
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .size_code (size_code),
        .put_value (put_value),
        .capacity  (eff_capacity),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    fbuf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign get_value    = result.get_value;
    assign status       = result.status;
    assign position_now = result.position;
    assign limit_now    = result.limit;

`ifndef SYNTHESIS
    a_pos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        position_now <= limit_now)
        else $error("position beyond limit");

    a_limit_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        limit_now <= 11'(DCAP))
        else $error("limit beyond store depth");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (get_value == 64'd0))
        else $error("refused access returned data");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither working nor done");
`endif

endmodule

FILE: verif/big_endian_field_buffer_tb.sv
`timescale 1ns / 1ps

module big_endian_field_buffer_tb;

    import fbuf_pkg::*;

    localparam int BUF_DEPTH   = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  size_code;
        logic [63:0] value;
        res_t        outcome;
    } field_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = OP_PUT;
    logic [1:0]  size_code = 2'd0;
    logic [63:0] put_value = '0;
    logic        done;
    logic [63:0] get_value;
    logic [1:0]  status;
    logic [10:0] position_now;
    logic [10:0] limit_now;
    logic        buffer_capacity_write = 1'b0;
    logic [10:0] buffer_capacity = CAP_RESET;

    field_cmd_t cmd_q [$];
    res_t       expected_q [$];

    logic [7:0]  shadow_bytes [0:BUF_DEPTH-1];
    bit          shadow_written [0:BUF_DEPTH-1];
    int          cur_pos;
    int          cur_lim;
    logic [10:0] cap_reg;
    logic [1:0]  last_status;

    bit no_idle_run = 1'b0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int n_taken = 0;
    int n_results = 0;
    int n_put = 0;
    int n_get = 0;
    int n_flip = 0;
    int n_clear = 0;
    int n_overflow = 0;
    int n_underflow = 0;
    int n_cap_writes = 0;

    int phase_cap [0:NUM_PHASES-1] = '{24, 5, 2047, 64, 0, 13, 1024, 1, 300, 40};
    int phase_len [0:NUM_PHASES-1] = '{30, 30, 30, 40, 20, 30, 260, 20, 40, 30};

    big_endian_field_buffer #(
        .DEPTH(BUF_DEPTH)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .opcode               (opcode),
        .size_code            (size_code),
        .put_value            (put_value),
        .done                 (done),
        .get_value            (get_value),
        .status               (status),
        .position_now         (position_now),
        .limit_now            (limit_now),
        .buffer_capacity_write(buffer_capacity_write),
        .buffer_capacity      (buffer_capacity)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic res_t predict_access(input logic [1:0] op, input logic [1:0] sz,
                                            input logic [63:0] val);
        res_t r;
        int nbytes;
        int k;
        r = '0;
        nbytes = 1 << sz;
        case (op)
            OP_PUT:
            begin
                if (cur_pos + nbytes > cur_lim)
                    r.status = ST_OVERFLOW;
                else
                begin
                    for (k = 0; k < nbytes; k++)
                    begin
                        shadow_bytes[cur_pos + k] = val[8 * (nbytes - 1 - k) +: 8];
                        shadow_written[cur_pos + k] = 1'b1;
                    end
                    cur_pos += nbytes;
                end
            end
            OP_GET:
            begin
                if (cur_pos + nbytes > cur_lim)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    for (k = 0; k < nbytes; k++)
                        r.get_value = {r.get_value[55:0], shadow_bytes[cur_pos + k]};
                    cur_pos += nbytes;
                end
            end
            OP_FLIP:
            begin
                cur_lim = cur_pos;
                cur_pos = 0;
            end
            default:
            begin
                cur_pos = 0;
                cur_lim = (cap_reg > BUF_DEPTH) ? BUF_DEPTH : int'(cap_reg);
            end
        endcase
        r.position = cur_pos[10:0];
        r.limit = cur_lim[10:0];
        return r;
    endfunction

    function automatic bit get_hits_blank(input logic [1:0] sz);
        int nbytes;
        int k;
        bit blank;
        nbytes = 1 << sz;
        blank = 1'b0;
        if (cur_pos + nbytes <= cur_lim)
            for (k = 0; k < nbytes; k++)
                if (!shadow_written[cur_pos + k])
                    blank = 1'b1;
        return blank;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_word(input logic [1:0] op, input logic [1:0] sz,
                              input logic [63:0] val);
        field_cmd_t c;
        // steer clear of reading bytes never written
        if (op == OP_GET && get_hits_blank(sz))
            op = OP_PUT;
        c.op = op;
        c.size_code = sz;
        c.value = val;
        c.outcome = predict_access(op, sz, val);
        last_status = c.outcome.status;
        case (op)
            OP_PUT:   n_put++;
            OP_GET:   n_get++;
            OP_FLIP:  n_flip++;
            default:  n_clear++;
        endcase
        if (c.outcome.status == ST_OVERFLOW)
            n_overflow++;
        if (c.outcome.status == ST_UNDERFLOW)
            n_underflow++;
        cmd_q.push_back(c);
    endtask

    task automatic log_error(input string what, input res_t want, input res_t seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: want value=%h status=%0d pos=%0d lim=%0d, %s",
                     what, want.get_value, want.status, want.position, want.limit,
                     $sformatf("got value=%h status=%0d pos=%0d lim=%0d",
                               seen.get_value, seen.status, seen.position,
                               seen.limit));
    endtask

    task automatic wait_idle();
        while (cmd_q.size() != 0 || expected_q.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [10:0] v);
        wait_idle();
        @(posedge clk);
        buffer_capacity_write <= 1'b1;
        buffer_capacity <= v;
        @(posedge clk);
        buffer_capacity_write <= 1'b0;
        cap_reg = v;
        n_cap_writes++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : word_driver
        bit taken;
        bit hold_off;
        field_cmd_t head;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            hold_off = !no_idle_run && ($urandom_range(0, 99) < 21);
            if (taken)
            begin
                head = cmd_q.pop_front();
                expected_q.push_back(head.outcome);
                n_taken++;
            end
            // hold the word while busy, else advance or idle
            if (!start || taken)
            begin
                if (cmd_q.size() != 0 && !hold_off)
                begin
                    start <= 1'b1;
                    opcode <= cmd_q[0].op;
                    size_code <= cmd_q[0].size_code;
                    put_value <= cmd_q[0].value;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        res_t seen;
        res_t want;
        if (rst_n && done)
        begin
            seen.get_value = get_value;
            seen.status = status;
            seen.position = position_now;
            seen.limit = limit_now;
            n_results++;
            if (expected_q.size() == 0)
                log_error("result with no word outstanding", '0, seen);
            else
            begin
                want = expected_q.pop_front();
                if (seen.get_value !== want.get_value || seen.status !== want.status ||
                    seen.position !== want.position || seen.limit !== want.limit)
                    log_error("mismatch", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done ||
                (cmd_q.size() == 0 && expected_q.size() == 0 && !busy))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("big_endian_field_buffer_tb: done, errors");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int p;
        int i;
        int roll;
        bit filling;
        bit full_span;
        logic [1:0] sz;

        cap_reg = CAP_RESET;
        cur_pos = 0;
        cur_lim = (cap_reg > BUF_DEPTH) ? BUF_DEPTH : int'(cap_reg);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // every width, garbage in unused upper bytes, then read back
        queue_word(OP_PUT, 2'd0, 64'hFFFF_FFFF_FFFF_FFA5);
        queue_word(OP_PUT, 2'd1, 64'h0123_4567_89AB_BEEF);
        queue_word(OP_PUT, 2'd2, 64'hFFFF_0000_DEAD_C0DE);
        queue_word(OP_PUT, 2'd3, '1);
        queue_word(OP_PUT, 2'd3, '0);
        queue_word(OP_PUT, 2'd3, 64'h8000_0000_0000_0001);
        queue_word(OP_FLIP, 2'd3, rand_word());
        queue_word(OP_GET, 2'd0, rand_word());
        queue_word(OP_GET, 2'd1, rand_word());
        queue_word(OP_GET, 2'd2, rand_word());
        queue_word(OP_GET, 2'd3, rand_word());
        queue_word(OP_GET, 2'd3, rand_word());
        queue_word(OP_GET, 2'd3, rand_word());
        // access at the limit is refused
        queue_word(OP_GET, 2'd0, rand_word());
        queue_word(OP_PUT, 2'd0, rand_word());
        queue_word(OP_CLEAR, 2'd2, rand_word());
        // flip at position zero leaves an empty window
        queue_word(OP_FLIP, 2'd1, rand_word());
        queue_word(OP_GET, 2'd0, rand_word());
        queue_word(OP_PUT, 2'd0, rand_word());
        queue_word(OP_CLEAR, 2'd1, rand_word());

        // capacity dropped below the limit only bites after clear
        write_capacity(11'd1);
        queue_word(OP_PUT, 2'd1, rand_word());
        queue_word(OP_CLEAR, 2'd3, rand_word());
        queue_word(OP_PUT, 2'd1, rand_word());
        queue_word(OP_PUT, 2'd0, rand_word());
        queue_word(OP_PUT, 2'd0, rand_word());
        queue_word(OP_FLIP, 2'd0, rand_word());
        queue_word(OP_GET, 2'd0, rand_word());

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_cap[p][10:0]);
            full_span = (phase_cap[p] == BUF_DEPTH);
            no_idle_run = full_span;
            filling = 1'b1;
            queue_word(OP_CLEAR, 2'($urandom_range(0, 3)), rand_word());
            for (i = 1; i < phase_len[p]; i++)
            begin
                roll = $urandom_range(0, 99);
                sz = 2'($urandom_range(0, 3));
                if (full_span && $urandom_range(0, 9) != 0)
                    sz = 2'd3;
                if (roll < 12 && !full_span)
                    queue_word(2'($urandom_range(0, 3)), sz, rand_word());
                else if (filling)
                begin
                    if ((last_status == ST_OVERFLOW && roll < 90) || (roll > 97 && !full_span))
                    begin
                        queue_word(OP_FLIP, sz, rand_word());
                        filling = 1'b0;
                    end
                    else
                        queue_word(OP_PUT, sz, rand_word());
                end
                else
                begin
                    if ((last_status == ST_UNDERFLOW && roll < 90) || (roll > 97 && !full_span))
                    begin
                        queue_word(OP_CLEAR, sz, rand_word());
                        filling = 1'b1;
                    end
                    else
                        queue_word(OP_GET, sz, rand_word());
                end
            end
        end

        wait_idle();
        no_idle_run = 1'b0;
        repeat (20) @(negedge clk);
        while (expected_q.size() != 0)
            log_error("no result for word", expected_q.pop_front(), '0);

        $display("covered %0d words (%0d put, %0d get, %0d flip, %0d clear), %0d results",
                 n_taken, n_put, n_get, n_flip, n_clear, n_results);
        $display("refused %0d overflow and %0d underflow, %0d capacity writes, %0d errors",
                 n_overflow, n_underflow, n_cap_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("big_endian_field_buffer_tb: done, clean");
        else
            $display("big_endian_field_buffer_tb: done, errors");
        $finish;
    end

endmodule
